// ----- hw/rtl/b64sc_pkg.sv -----
// Shared types, constants and alphabet functions for the base64 stream codec.
// No dependencies; imported by every module of the codec.
`default_nettype none

package b64sc_pkg;

	localparam logic       DIR_ENC     = 1'b0;
	localparam logic       DIR_DEC     = 1'b1;
	localparam logic [7:0] PAD_CHAR    = 8'h3D;
	localparam int         QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [7:0] data_in;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       run_last;
		logic       bad_char;
	} out_item_t;

	// one finished group, handed from the front to the back
	typedef struct packed {
		logic        dir;       // DIR_ENC or DIR_DEC
		logic [23:0] hold;      // group, left aligned
		logic [1:0]  last_idx;  // index of the final result of the group
		logic [1:0]  real_idx;  // encode: chars above this index are pad
		logic        bad;       // decode: group held a bad character
	} job_t;

	typedef struct packed {
		logic       ok;
		logic [5:0] val;
	} char_val_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26)
			c = 8'h41 + {2'b00, v};
		else if (v < 6'd52)
			c = 8'h61 + {2'b00, v - 6'd26};
		else if (v < 6'd62)
			c = 8'h30 + {2'b00, v - 6'd52};
		else if (v == 6'd62)
			c = 8'h2B;
		else
			c = 8'h2F;
		return c;
	endfunction

	function automatic char_val_t b64_value(input logic [7:0] c);
		char_val_t r;
		r.ok  = 1'b1;
		r.val = 6'd0;
		if (c >= 8'h41 && c <= 8'h5A)
			r.val = 6'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7A)
			r.val = 6'(c - 8'h61 + 8'd26);
		else if (c >= 8'h30 && c <= 8'h39)
			r.val = 6'(c - 8'h30 + 8'd52);
		else if (c == 8'h2B)
			r.val = 6'd62;
		else if (c == 8'h2F)
			r.val = 6'd63;
		else
			r.ok = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/b64sc_front.sv -----
// Front end: gathers input transactions into groups and issues finished groups.
// Depends on b64sc_pkg.
`default_nettype none

module b64sc_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic                cfg_dir,
	input  wire logic                take,
	input  wire b64sc_pkg::in_item_t item,
	output logic                     push,
	output b64sc_pkg::job_t          job,
	output logic [1:0]               grp_count
);
	import b64sc_pkg::*;

	logic        dir_q;
	logic [23:0] hold_q;
	logic [1:0]  cnt_q;
	logic [1:0]  pad_q;
	logic        bad_q;

	logic [2:0]  n;
	logic [23:0] hold_enc, hold_dec, t_enc, t_dec;
	char_val_t   cv;
	logic        is_pad;
	logic [5:0]  v;
	logic [1:0]  pad_nx;
	logic        bad_nx;
	logic        done;
	logic [2:0]  drop_sum;
	logic [1:0]  drop;

	always_comb begin
		n        = {1'b0, cnt_q} + 3'd1;
		hold_enc = {hold_q[15:0], item.data_in};
		cv       = b64_value(item.data_in);
		is_pad   = (item.data_in == PAD_CHAR);
		v        = is_pad ? 6'd0 : cv.val;
		pad_nx   = is_pad ? ((pad_q == 2'd2) ? 2'd2 : pad_q + 2'd1) : 2'd0;
		bad_nx   = bad_q | (!is_pad && !cv.ok);
		hold_dec = {hold_q[17:0], v};

		if (dir_q == DIR_DEC)
			done = (n == 3'd4) || item.end_of_message;
		else
			done = (n == 3'd3) || item.end_of_message;

		case (n)
			3'd1:    t_enc = {hold_enc[7:0], 16'h0000};
			3'd2:    t_enc = {hold_enc[15:0], 8'h00};
			default: t_enc = hold_enc;
		endcase

		case (n)
			3'd1:    t_dec = {hold_dec[5:0], 18'd0};
			3'd2:    t_dec = {hold_dec[11:0], 12'd0};
			3'd3:    t_dec = {hold_dec[17:0], 6'd0};
			default: t_dec = hold_dec;
		endcase

		// missing characters of a short final group count as padding
		drop_sum = {1'b0, pad_nx} + (3'd4 - n);
		if (!item.end_of_message)
			drop = 2'd0;
		else if (drop_sum > 3'd2)
			drop = 2'd2;
		else
			drop = drop_sum[1:0];

		job.dir = dir_q;
		if (dir_q == DIR_DEC) begin
			job.hold     = t_dec;
			job.last_idx = 2'd2 - drop;
			job.real_idx = 2'd3;
			job.bad      = bad_nx;
		end else begin
			job.hold     = t_enc;
			job.last_idx = 2'd3;
			job.real_idx = n[1:0];
			job.bad      = 1'b0;
		end

		push = take && done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= DIR_ENC;
			hold_q <= '0;
			cnt_q  <= '0;
			pad_q  <= '0;
			bad_q  <= 1'b0;
		end else if (cfg_we) begin
			dir_q  <= cfg_dir;
			hold_q <= '0;
			cnt_q  <= '0;
			pad_q  <= '0;
			bad_q  <= 1'b0;
		end else if (take) begin
			if (done) begin
				hold_q <= '0;
				cnt_q  <= '0;
				pad_q  <= '0;
				bad_q  <= 1'b0;
			end else if (dir_q == DIR_DEC) begin
				hold_q <= hold_dec;
				cnt_q  <= n[1:0];
				pad_q  <= pad_nx;
				bad_q  <= bad_nx;
			end else begin
				hold_q <= hold_enc;
				cnt_q  <= n[1:0];
			end
		end
	end

	assign grp_count = cnt_q;

endmodule

`default_nettype wire

// ----- hw/rtl/b64sc_queue.sv -----
// Short group queue between the front end and the back end.
// Depends on b64sc_pkg.
`default_nettype none

module b64sc_queue #(
	parameter int DEPTH = b64sc_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire b64sc_pkg::job_t  wr_job,
	input  wire logic             pop,
	output logic                  full,
	output logic                  nonempty,
	output b64sc_pkg::job_t       head
);
	import b64sc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/b64sc_back.sv -----
// Back end: expands queued groups into result transactions, one per cycle while
// res_stall is low, through an output register. Depends on b64sc_pkg.
`default_nettype none

module b64sc_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire b64sc_pkg::job_t  q_head,
	output logic                  q_pop,
	output logic [1:0]            res_idx,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output b64sc_pkg::out_item_t  res_item
);
	import b64sc_pkg::*;

	logic [1:0] k_q;
	logic       res_valid_q;
	out_item_t  res_item_q;
	logic       load;
	logic [5:0] six;
	logic [7:0] byte_v;
	out_item_t  nxt;

	always_comb begin
		load = q_valid && (!res_valid_q || !res_stall);

		case (k_q)
			2'd0:    six = q_head.hold[23:18];
			2'd1:    six = q_head.hold[17:12];
			2'd2:    six = q_head.hold[11:6];
			default: six = q_head.hold[5:0];
		endcase

		case (k_q)
			2'd0:    byte_v = q_head.hold[23:16];
			2'd1:    byte_v = q_head.hold[15:8];
			default: byte_v = q_head.hold[7:0];
		endcase

		nxt.run_last = (k_q == q_head.last_idx);
		if (q_head.dir == DIR_DEC) begin
			nxt.data_out = byte_v;
			nxt.bad_char = q_head.bad;
		end else begin
			nxt.data_out = (k_q > q_head.real_idx) ? PAD_CHAR : b64_char(six);
			nxt.bad_char = 1'b0;
		end

		q_pop = load && nxt.run_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load)
				k_q <= nxt.run_last ? 2'd0 : k_q + 2'd1;
			if (!res_valid_q || !res_stall)
				res_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_item_q <= nxt;
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;
	assign res_idx   = k_q;

endmodule

`default_nettype wire

// ----- hw/rtl/base64_stream_codec_core.sv -----
// Base64 stream codec, top level. Depends on b64sc_pkg, b64sc_front, b64sc_queue, b64sc_back.
// A closing transaction writes its group into the queue; results leave through the output register.
// Throughput while res_stall is low: one input per cycle, one result per cycle; the single result
// port limits encoding, as three inputs yield four results; decoding runs at 1 input per cycle.
// Reset: arst_n clears direction (encode), the partial group, the queue and the output.
`default_nettype none

module base64_stream_codec_core #(
	parameter int QUEUE_DEPTH = b64sc_pkg::QUEUE_DEPTH  // power of two, 2 or more
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input channel
	input  wire logic                 src_valid,
	output logic                      src_stall,
	input  wire b64sc_pkg::in_item_t  src_item,
	// result channel
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output b64sc_pkg::out_item_t      res_item,
	// direction register write channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic                 cfg_data
);
	import b64sc_pkg::*;

	logic       take;
	logic       push;
	job_t       job;
	logic [1:0] grp_count;
	logic       q_full;
	logic       q_valid;
	job_t       q_head;
	logic       q_pop;
	logic [1:0] res_idx;
	logic       cfg_we;

	// Direction writes are always taken; the write clears any partial group.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Front stalls on a full queue, also for items that don't close a group.
	assign src_stall = q_full;
	assign take      = src_valid && !src_stall;

	// Front: collects bytes (encode) or characters (decode) into a 24-bit group
	// and issues it with result count, pad position and bad-char flag.
	b64sc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_dir   (cfg_data),
		.take      (take),
		.item      (src_item),
		.push      (push),
		.job       (job),
		.grp_count (grp_count)
	);

	// Queue: decouples input acceptance from result expansion.
	b64sc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_job   (job),
		.pop      (q_pop),
		.full     (q_full),
		.nonempty (q_valid),
		.head     (q_head)
	);

	// Back: walks the head group one result per cycle, while res_stall is low, into the output register.
	b64sc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.res_idx   (res_idx),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_item  (res_item)
	);

	// Result index of the back end never runs past the group's final result.
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_valid |-> (res_idx <= q_head.last_idx))
		else $error("result index beyond last result of group");

	// With nothing queued the back end sits at the start of a group.
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!q_valid |-> (res_idx == 2'd0))
		else $error("result index not at zero while queue empty");

	// A direction write discards the partial group.
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (grp_count == 2'd0))
		else $error("partial group survived a direction write");

	// Encode groups always hold four results.
	a_enc_four: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_head.dir == DIR_ENC) |-> (q_head.last_idx == 2'd3))
		else $error("encode group without four results");

endmodule

`default_nettype wire
